>>> rtl/ssc_pkg.sv
package ssc_pkg;

    // Item kinds
    localparam logic [1:0] FUNC_TICK     = 2'd0;
    localparam logic [1:0] FUNC_CMP      = 2'd1;
    localparam logic [1:0] FUNC_THROTTLE = 2'd2;

    // Motor modes
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_WAIT  = 2'd2;
    localparam logic [1:0] MODE_RUN   = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_STALL_TIMEOUT    = 3'd0;
    localparam logic [2:0] REG_BRAKE_LEVEL      = 3'd1;
    localparam logic [2:0] REG_RAMP_STEP        = 3'd2;
    localparam logic [2:0] REG_START_DUTY       = 3'd3;
    localparam logic [2:0] REG_START_STEP_TICKS = 3'd4;
    localparam logic [2:0] REG_START_STEPS      = 3'd5;
    localparam logic [2:0] REG_QUALIFY_SAMPLES  = 3'd6;
    localparam logic [2:0] REG_MIN_DUTY         = 3'd7;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Duty above which an idle motor starts
    localparam logic [7:0] START_LEVEL = 8'd20;
    localparam logic [7:0] COMPARE_MAX = 8'hFF;
    localparam logic [7:0] COMPARE_MIN = 8'h00;
    localparam logic [9:0] ADC_FULL    = 10'd1023;

    // Entries 0..2 are the high sides of phases 1..3, entries 3..5 the low sides
    typedef logic [5:0][7:0] gates_t;

    localparam gates_t GATES_OFF = {COMPARE_MAX, COMPARE_MAX, COMPARE_MAX,
                                    COMPARE_MIN, COMPARE_MIN, COMPARE_MIN};

    function automatic logic [1:0] hi_phase(input logic [2:0] s);
        logic [1:0] p;
        unique case (s)
            3'd0, 3'd1: p = 2'd0;
            3'd2, 3'd3: p = 2'd1;
            3'd4, 3'd5: p = 2'd2;
            default:    p = 2'd0;
        endcase
        return p;
    endfunction

    function automatic logic [1:0] lo_phase(input logic [2:0] s);
        logic [1:0] p;
        unique case (s)
            3'd0, 3'd5: p = 2'd1;
            3'd1, 3'd2: p = 2'd2;
            3'd3, 3'd4: p = 2'd0;
            default:    p = 2'd1;
        endcase
        return p;
    endfunction

    function automatic logic [1:0] edge_phase(input logic [2:0] s);
        logic [1:0] p;
        unique case (s)
            3'd0, 3'd3: p = 2'd2;
            3'd1, 3'd4: p = 2'd1;
            3'd2, 3'd5: p = 2'd0;
            default:    p = 2'd2;
        endcase
        return p;
    endfunction

    // Wanted comparator level: rising edge on even steps
    function automatic logic edge_rise(input logic [2:0] s);
        return ~s[0];
    endfunction

    function automatic gates_t apply_step(input logic [2:0] s, input logic [7:0] duty,
                                          input logic [7:0] brake);
        gates_t     g;
        logic [1:0] h;
        logic [1:0] l;
        g = GATES_OFF;
        h = hi_phase(s);
        l = lo_phase(s);
        g[{1'b0, h}] = duty;
        g[{1'b0, h} + 3'd3] = (duty != COMPARE_MIN) ? COMPARE_MAX : (COMPARE_MAX - brake);
        g[{1'b0, l} + 3'd3] = COMPARE_MIN;
        return g;
    endfunction

endpackage

>>> rtl/sensorless_six_step_commutator_top.sv
// Six-step sensorless commutator for a three-phase brushless motor.
//
// Input channel (in_valid/in_ready): one transaction per timer tick, comparator
// sample or throttle sample, selected by func. Output channel (out_valid/
// out_ready): exactly one transaction per input, carrying the six gate compare
// values, the commutation step, the mode and the gated drive duty after that
// input has been applied.
// An accepted input passes from the input register into the state registers,
// which drive the output. Throughput: one transaction per cycle while the
// output is not stalled; all per-item work (timer add, throttle scale by shift
// and one correcting compare, qualify count, step table) sits in one stage
// between the input and the state registers. The state registers double as
// the output register: state only moves when the output slot is free or being
// emptied, so they always hold the result of the last transaction.
// Reset: motor idle, gates off (high sides 0, low sides 255), timers and
// throttle ramp cleared, configuration at its defaults; no clearing pass.
// Stall: when out_ready is low the result holds, the input register keeps one
// waiting transaction, and in_ready drops until the output is taken.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data; the user must
// write it only while no transaction is in flight, the block does not enforce it.
module sensorless_six_step_commutator_top
    import ssc_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             func,
    input  logic [2:0]             bemf_levels,
    input  logic [9:0]             throttle_adc,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             high1,
    output logic [7:0]             high2,
    output logic [7:0]             high3,
    output logic [7:0]             low1,
    output logic [7:0]             low2,
    output logic [7:0]             low3,
    output logic [2:0]             step_now,
    output logic [1:0]             mode_now,
    output logic [7:0]             drive_duty
);

    // Timer comparisons run at the wider of the timer and the 16-bit limits
    localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    // ---------------- configuration registers ----------------
    logic [15:0] stall_timeout_reg;
    logic [7:0]  brake_level_reg;
    logic [7:0]  ramp_step_reg;
    logic [7:0]  start_duty_reg;
    logic [15:0] start_step_ticks_reg;
    logic [7:0]  start_steps_reg;
    logic [3:0]  qualify_samples_reg;
    logic [7:0]  min_duty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_timeout_reg    <= 16'd1072;
            brake_level_reg      <= 8'd20;
            ramp_step_reg        <= 8'd2;
            start_duty_reg       <= 8'd30;
            start_step_ticks_reg <= 16'd144;
            start_steps_reg      <= 8'd12;
            qualify_samples_reg  <= 4'd10;
            min_duty_reg         <= 8'd15;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_STALL_TIMEOUT:    stall_timeout_reg    <= cfg_data;
                REG_BRAKE_LEVEL:      brake_level_reg      <= cfg_data[7:0];
                REG_RAMP_STEP:        ramp_step_reg        <= cfg_data[7:0];
                REG_START_DUTY:       start_duty_reg       <= cfg_data[7:0];
                REG_START_STEP_TICKS: start_step_ticks_reg <= cfg_data;
                REG_START_STEPS:      start_steps_reg      <= cfg_data[7:0];
                REG_QUALIFY_SAMPLES:  qualify_samples_reg  <= cfg_data[3:0];
                REG_MIN_DUTY:         min_duty_reg         <= cfg_data[7:0];
                default:              ;
            endcase
        end
    end

    // ---------------- input register and handshake ----------------
    logic       in_valid_reg;
    logic [1:0] func_reg;
    logic [2:0] levels_reg;
    logic [9:0] adc_reg;
    logic       out_valid_reg;
    logic       advance;

    // Move the held transaction into state when the output slot can take it
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload holds no reset value
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            func_reg   <= func;
            levels_reg <= bemf_levels;
            adc_reg    <= throttle_adc;
        end
    end

    // ---------------- state ----------------
    logic [TIMER_BITS-1:0] tick_count_reg, tick_count_next;
    logic [TIMER_BITS-1:0] step_start_reg, step_start_next;
    logic [TIMER_BITS-1:0] lock_watch_reg, lock_watch_next;
    logic [2:0]            step_reg, step_next;
    logic [1:0]            mode_reg, mode_next;
    logic [7:0]            forced_count_reg, forced_count_next;
    logic [3:0]            match_count_reg, match_count_next;
    logic [7:0]            ramp_level_reg, ramp_level_next;
    logic [7:0]            duty_reg, duty_next;
    gates_t                gate_compare_reg, gate_compare_next;

    // ---------------- throttle: target = adc*255/1023 ----------------
    // Divide by 1023 as shift by 10 plus one correcting compare: the remainder
    // estimate stays below twice the divisor.
    logic [17:0] thr_prod;
    logic [7:0]  thr_quot;
    logic [10:0] thr_rem;
    logic [7:0]  thr_target;
    logic [8:0]  ramp_sum;
    logic [7:0]  thr_ramp;
    logic [7:0]  thr_duty;

    always_comb
    begin
        thr_prod   = {adc_reg, 8'd0} - {8'd0, adc_reg};
        thr_quot   = thr_prod[17:10];
        thr_rem    = {1'b0, thr_prod[9:0]} + {3'd0, thr_quot};
        thr_target = thr_quot + {7'd0, (thr_rem >= {1'b0, ADC_FULL})};
        ramp_sum   = {1'b0, ramp_level_reg} + {1'b0, ramp_step_reg};
        if (adc_reg >= {2'd0, min_duty_reg})
        begin
            // Ramp up gently, cut down at once
            if (ramp_level_reg < thr_target && ramp_sum <= {1'b0, COMPARE_MAX})
            begin
                thr_ramp = ramp_sum[7:0];
            end
            else
            begin
                thr_ramp = thr_target;
            end
        end
        else
        begin
            thr_ramp = 8'd0;
        end
        // Gate out pulses below the minimum duty
        thr_duty = (thr_ramp < min_duty_reg) ? 8'd0 : thr_ramp;
    end

    // ---------------- back-EMF edge qualification ----------------
    logic       edge_match;
    logic [3:0] qual_need;
    logic [4:0] match_inc;
    logic       qualified;
    logic [3:0] qual_count;
    logic [2:0] step_inc;

    always_comb
    begin
        edge_match = (levels_reg[edge_phase(step_reg)] == edge_rise(step_reg));
        qual_need  = (qualify_samples_reg == 4'd0) ? 4'd1 : qualify_samples_reg;
        match_inc  = {1'b0, match_count_reg} + 5'd1;
        qualified  = edge_match && (match_inc >= {1'b0, qual_need});
        // Drop the count on a mismatch and after a qualified edge
        qual_count = (edge_match && !qualified) ? match_inc[3:0] : 4'd0;
        step_inc   = (step_reg == 3'd5) ? 3'd0 : step_reg + 3'd1;
    end

    // ---------------- per-transaction update ----------------
    logic [TIMER_BITS-1:0] elapsed;

    always_comb
    begin
        tick_count_next   = tick_count_reg;
        step_start_next   = step_start_reg;
        lock_watch_next   = lock_watch_reg;
        step_next         = step_reg;
        mode_next         = mode_reg;
        forced_count_next = forced_count_reg;
        match_count_next  = match_count_reg;
        ramp_level_next   = ramp_level_reg;
        duty_next         = duty_reg;
        gate_compare_next = gate_compare_reg;
        elapsed           = tick_count_reg - step_start_reg;

        if (advance)
        begin
            // Event-specific update first
            if (func_reg == FUNC_TICK)
            begin
                tick_count_next = tick_count_reg + TIMER_BITS'(1);
                lock_watch_next = lock_watch_reg + TIMER_BITS'(1);
            end
            else if (func_reg == FUNC_THROTTLE)
            begin
                ramp_level_next = thr_ramp;
                duty_next       = thr_duty;
            end

            elapsed = tick_count_next - step_start_reg;

            // Then the mode sequencer
            unique case (mode_reg)
                MODE_IDLE:
                begin
                    if (duty_next > START_LEVEL)
                    begin
                        step_start_next   = tick_count_next;
                        step_next         = 3'd0;
                        forced_count_next = 8'd0;
                        match_count_next  = 4'd0;
                        gate_compare_next = apply_step(3'd0, start_duty_reg, brake_level_reg);
                        mode_next = (start_steps_reg == 8'd0) ? MODE_WAIT : MODE_START;
                    end
                    else
                    begin
                        gate_compare_next = GATES_OFF;
                    end
                end
                MODE_START:
                begin
                    if (CMP_W'(elapsed) > CMP_W'(start_step_ticks_reg))
                    begin
                        step_next         = step_inc;
                        gate_compare_next = apply_step(step_inc, start_duty_reg,
                                                       brake_level_reg);
                        step_start_next   = tick_count_next;
                        forced_count_next = forced_count_reg + 8'd1;
                    end
                    if (forced_count_next >= start_steps_reg)
                    begin
                        mode_next        = MODE_WAIT;
                        match_count_next = 4'd0;
                    end
                end
                MODE_WAIT:
                begin
                    if (CMP_W'(elapsed) >= CMP_W'(stall_timeout_reg))
                    begin
                        mode_next         = MODE_IDLE;
                        match_count_next  = 4'd0;
                        gate_compare_next = GATES_OFF;
                    end
                    else if (func_reg == FUNC_CMP)
                    begin
                        match_count_next = qual_count;
                        if (qualified)
                        begin
                            // First edge: lock and hand over to closed loop
                            lock_watch_next   = '0;
                            step_next         = step_inc;
                            gate_compare_next = apply_step(step_inc, start_duty_reg,
                                                           brake_level_reg);
                            ramp_level_next   = start_duty_reg;
                            duty_next         = start_duty_reg;
                            mode_next         = MODE_RUN;
                        end
                    end
                end
                MODE_RUN:
                begin
                    if (func_reg == FUNC_CMP)
                    begin
                        match_count_next = qual_count;
                        if (qualified)
                        begin
                            lock_watch_next   = '0;
                            step_next         = step_inc;
                            gate_compare_next = apply_step(step_inc, duty_next,
                                                           brake_level_reg);
                        end
                    end
                    // Watchdog after any edge: drop to idle on loss of lock
                    if (CMP_W'(lock_watch_next) > CMP_W'(stall_timeout_reg))
                    begin
                        mode_next         = MODE_IDLE;
                        match_count_next  = 4'd0;
                        gate_compare_next = GATES_OFF;
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg   <= '0;
            step_start_reg   <= '0;
            lock_watch_reg   <= '0;
            step_reg         <= 3'd0;
            mode_reg         <= MODE_IDLE;
            forced_count_reg <= 8'd0;
            match_count_reg  <= 4'd0;
            ramp_level_reg   <= 8'd0;
            duty_reg         <= 8'd0;
            gate_compare_reg <= GATES_OFF;
        end
        else
        begin
            tick_count_reg   <= tick_count_next;
            step_start_reg   <= step_start_next;
            lock_watch_reg   <= lock_watch_next;
            step_reg         <= step_next;
            mode_reg         <= mode_next;
            forced_count_reg <= forced_count_next;
            match_count_reg  <= match_count_next;
            ramp_level_reg   <= ramp_level_next;
            duty_reg         <= duty_next;
            gate_compare_reg <= gate_compare_next;
        end
    end

    // ---------------- outputs straight from state ----------------
    assign out_valid  = out_valid_reg;
    assign high1      = gate_compare_reg[0];
    assign high2      = gate_compare_reg[1];
    assign high3      = gate_compare_reg[2];
    assign low1       = gate_compare_reg[3];
    assign low2       = gate_compare_reg[4];
    assign low3       = gate_compare_reg[5];
    assign step_now   = step_reg;
    assign mode_now   = mode_reg;
    assign drive_duty = duty_reg;

endmodule

>>> rtl/ssc_checker.sv
module ssc_checker
    import ssc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] high1,
    input logic [7:0] high2,
    input logic [7:0] high3,
    input logic [7:0] low1,
    input logic [7:0] low2,
    input logic [7:0] low3,
    input logic [2:0] step_now,
    input logic [1:0] mode_now,
    input logic [7:0] drive_duty
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid &&
            $stable({high1, high2, high3, low1, low2, low3, step_now, mode_now, drive_duty}))
        else $error("result changed while stalled");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> step_now <= 3'd5)
        else $error("commutation step out of range");

    // Idle motor drives nothing
    a_idle_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode_now == MODE_IDLE |->
            high1 == COMPARE_MIN && high2 == COMPARE_MIN && high3 == COMPARE_MIN &&
            low1 == COMPARE_MAX && low2 == COMPARE_MAX && low3 == COMPARE_MAX)
        else $error("gates driven in idle");

    // Never more than one high side switching
    a_one_high: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $countones({high1 != COMPARE_MIN, high2 != COMPARE_MIN,
                                  high3 != COMPARE_MIN}) <= 1)
        else $error("more than one high side driven");

endmodule

bind sensorless_six_step_commutator_top ssc_checker u_ssc_checker (.*);
